>>> rtl/dec_pkg.sv
// ---------------------------------------------------------------------------
// dec_pkg
// Shared widths, the queue word type and the saturating velocity update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dec_pkg;

   localparam int VW    = 32;  // Q16.16 velocity / position
   localparam int MW    = 8;   // mass
   localparam int RW    = 16;  // radius
   localparam int DW    = 33;  // exact centre offset, signed
   localparam int SQW   = 66;  // squared offsets
   localparam int EMW   = 15;  // normalized direction magnitude
   localparam int EW    = 16;  // normalized direction, signed
   localparam int DOTW  = 50;  // dot product, signed
   localparam int ADW   = 49;  // |dot|
   localparam int PRW   = 64;  // |dot| * |e|
   localparam int TMW   = 9;   // twice a mass
   localparam int NUMW  = 74;  // dividend
   localparam int DENW  = 40;  // divisor
   localparam int QW    = 34;  // quotient bits, |correction| < 2^34
   localparam int POSW  = 6;   // bit index into a 33 bit offset
   localparam int NORM  = 14;  // normalized MSB position
   localparam int SUMW  = 36;

   typedef struct packed {
      logic                  touch;
      logic                  apply;
      logic                  dot_neg;
      logic                  ex_neg;
      logic                  ey_neg;
      logic [PRW-1:0]        px;
      logic [PRW-1:0]        py;
      logic [DENW-1:0]       den;
      logic [MW-1:0]         ma;
      logic [MW-1:0]         mb;
      logic signed [VW-1:0]  avx;
      logic signed [VW-1:0]  avy;
      logic signed [VW-1:0]  bvx;
      logic signed [VW-1:0]  bvy;
   } dec_word_type;

   // v + (neg ? -m : m), clamped to the signed 32 bit range
   function automatic logic signed [VW-1:0] sat_add(logic signed [VW-1:0] v,
                                                   logic [QW-1:0] m, logic neg);
      logic signed [SUMW-1:0] s;
      logic signed [SUMW-1:0] c;
      c = signed'({{(SUMW-QW){1'b0}}, m});
      s = signed'({{(SUMW-VW){v[VW-1]}}, v}) + (neg ? -c : c);
      // in range when every bit above bit 31 matches it
      if (s[SUMW-1:VW-1] == '0 || s[SUMW-1:VW-1] == '1)
         sat_add = s[VW-1:0];
      else if (s[SUMW-1])
         sat_add = {1'b1, {(VW-1){1'b0}}};
      else
         sat_add = {1'b0, {(VW-1){1'b1}}};
   endfunction

endpackage

`default_nettype wire

>>> rtl/dec_front.sv
// ---------------------------------------------------------------------------
// dec_front
// Contact test, guard classification, direction normalization, dot product
// and divisor. Six register stages, one pair per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dec_front
   import dec_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic signed [VW-1:0] a_pos_x,
   input  wire logic signed [VW-1:0] a_pos_y,
   input  wire logic signed [VW-1:0] a_vel_x,
   input  wire logic signed [VW-1:0] a_vel_y,
   input  wire logic [MW-1:0]        a_mass,
   input  wire logic [RW-1:0]        a_radius,
   input  wire logic signed [VW-1:0] b_pos_x,
   input  wire logic signed [VW-1:0] b_pos_y,
   input  wire logic signed [VW-1:0] b_vel_x,
   input  wire logic signed [VW-1:0] b_vel_y,
   input  wire logic [MW-1:0]        b_mass,
   input  wire logic [RW-1:0]        b_radius,
   output logic                      push,
   output dec_word_type              word
);

   // valid chain
   logic [5:0] v_ff, v_in;

   // stage 1
   logic                 dxn1_ff, dyn1_ff;
   logic [DW-1:0]        ux1_ff, uy1_ff, rq1_ff;
   logic signed [DW-1:0] dvx1_ff, dvy1_ff;
   logic signed [DW-1:0] dx_c, dy_c;
   logic [RW:0]          rsum_c;
   // velocities and masses ride along up to stage 5
   logic signed [VW-1:0] avx_ff[5], avy_ff[5], bvx_ff[5], bvy_ff[5];
   logic [MW-1:0]        ma_ff[5], mb_ff[5];

   // stage 2
   logic                 dxn2_ff, dyn2_ff, nz2_ff;
   logic [DW-1:0]        ux2_ff, uy2_ff;
   logic [SQW-1:0]       sqx2_ff, sqy2_ff, sqr2_ff;
   logic [POSW-1:0]      pos2_ff, pos_c;
   logic signed [DW-1:0] dvx2_ff, dvy2_ff;
   logic [DW-1:0]        mor_c;

   // stage 3
   logic                 touch3_ff, apply3_ff, dxn3_ff, dyn3_ff;
   logic [EMW-1:0]       aex3_ff, aey3_ff, aex_c, aey_c;
   logic signed [EW-1:0] ex3_ff, ey3_ff;
   logic signed [DW-1:0] dvx3_ff, dvy3_ff;
   logic [TMW-1:0]       msum3_ff;
   logic [SQW:0]         dsq_c;
   logic [POSW-1:0]      rsh_c, lsh_c;

   // stage 4
   logic                 touch4_ff, apply4_ff, dxn4_ff, dyn4_ff;
   logic [EMW-1:0]       aex4_ff, aey4_ff;
   logic signed [DOTW-2:0] prx4_ff, pry4_ff;
   logic [2*EMW-1:0]     esx4_ff, esy4_ff;
   logic [TMW-1:0]       msum4_ff;

   // stage 5
   logic                 touch5_ff, apply5_ff, dxn5_ff, dyn5_ff;
   logic [EMW-1:0]       aex5_ff, aey5_ff;
   logic signed [DOTW-1:0] dot5_ff;
   logic [DENW-1:0]      den5_ff;
   logic [2*EMW:0]       esq_c;

   // stage 6
   dec_word_type         w6_ff;
   logic [ADW-1:0]       adot_c;
   logic [DOTW-1:0]      dmag_c;

   always_comb begin
      v_in = {v_ff[4:0], accept};
      dx_c = signed'({b_pos_x[VW-1], b_pos_x}) - signed'({a_pos_x[VW-1], a_pos_x});
      dy_c = signed'({b_pos_y[VW-1], b_pos_y}) - signed'({a_pos_y[VW-1], a_pos_y});
      rsum_c = {1'b0, a_radius} + {1'b0, b_radius};

      // MSB of the larger magnitude is the MSB of their OR
      mor_c = ux1_ff | uy1_ff;
      pos_c = '0;
      for (int i = 0; i < DW; i++) begin
         if (mor_c[i]) pos_c = POSW'(i);
      end

      dsq_c = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      rsh_c = pos2_ff - POSW'(NORM);
      lsh_c = POSW'(NORM) - pos2_ff;
      if (pos2_ff >= POSW'(NORM)) begin
         aex_c = EMW'(ux2_ff >> rsh_c);
         aey_c = EMW'(uy2_ff >> rsh_c);
      end else begin
         aex_c = EMW'(ux2_ff << lsh_c);
         aey_c = EMW'(uy2_ff << lsh_c);
      end

      esq_c = {1'b0, esx4_ff} + {1'b0, esy4_ff};

      dmag_c = dot5_ff[DOTW-1] ? DOTW'(-dot5_ff) : DOTW'(dot5_ff);
      adot_c = dmag_c[ADW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end

      // stage 1
      dxn1_ff <= dx_c[DW-1];
      dyn1_ff <= dy_c[DW-1];
      ux1_ff  <= dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
      uy1_ff  <= dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
      rq1_ff  <= {rsum_c, 16'b0};
      dvx1_ff <= signed'({b_vel_x[VW-1], b_vel_x}) - signed'({a_vel_x[VW-1], a_vel_x});
      dvy1_ff <= signed'({b_vel_y[VW-1], b_vel_y}) - signed'({a_vel_y[VW-1], a_vel_y});
      avx_ff[0] <= a_vel_x;
      avy_ff[0] <= a_vel_y;
      bvx_ff[0] <= b_vel_x;
      bvy_ff[0] <= b_vel_y;
      ma_ff[0]  <= a_mass;
      mb_ff[0]  <= b_mass;
      for (int s = 1; s < 5; s++) begin
         avx_ff[s] <= avx_ff[s-1];
         avy_ff[s] <= avy_ff[s-1];
         bvx_ff[s] <= bvx_ff[s-1];
         bvy_ff[s] <= bvy_ff[s-1];
         ma_ff[s]  <= ma_ff[s-1];
         mb_ff[s]  <= mb_ff[s-1];
      end

      // stage 2: squares and leading one
      dxn2_ff <= dxn1_ff;
      dyn2_ff <= dyn1_ff;
      nz2_ff  <= |mor_c;
      ux2_ff  <= ux1_ff;
      uy2_ff  <= uy1_ff;
      sqx2_ff <= ux1_ff * ux1_ff;
      sqy2_ff <= uy1_ff * uy1_ff;
      sqr2_ff <= rq1_ff * rq1_ff;
      pos2_ff <= pos_c;
      dvx2_ff <= dvx1_ff;
      dvy2_ff <= dvy1_ff;

      // stage 3: contact test, guards, normalize
      touch3_ff <= dsq_c <= {1'b0, sqr2_ff};
      apply3_ff <= (dsq_c <= {1'b0, sqr2_ff}) && nz2_ff && ((ma_ff[1] | mb_ff[1]) != '0);
      dxn3_ff   <= dxn2_ff;
      dyn3_ff   <= dyn2_ff;
      aex3_ff   <= aex_c;
      aey3_ff   <= aey_c;
      ex3_ff    <= dxn2_ff ? -signed'({1'b0, aex_c}) : signed'({1'b0, aex_c});
      ey3_ff    <= dyn2_ff ? -signed'({1'b0, aey_c}) : signed'({1'b0, aey_c});
      dvx3_ff   <= dvx2_ff;
      dvy3_ff   <= dvy2_ff;
      msum3_ff  <= {1'b0, ma_ff[1]} + {1'b0, mb_ff[1]};

      // stage 4: products
      touch4_ff <= touch3_ff;
      apply4_ff <= apply3_ff;
      dxn4_ff   <= dxn3_ff;
      dyn4_ff   <= dyn3_ff;
      aex4_ff   <= aex3_ff;
      aey4_ff   <= aey3_ff;
      prx4_ff   <= dvx3_ff * ex3_ff;
      pry4_ff   <= dvy3_ff * ey3_ff;
      esx4_ff   <= aex3_ff * aex3_ff;
      esy4_ff   <= aey3_ff * aey3_ff;
      msum4_ff  <= msum3_ff;

      // stage 5: dot and divisor
      touch5_ff <= touch4_ff;
      apply5_ff <= apply4_ff;
      dxn5_ff   <= dxn4_ff;
      dyn5_ff   <= dyn4_ff;
      aex5_ff   <= aex4_ff;
      aey5_ff   <= aey4_ff;
      dot5_ff   <= signed'({prx4_ff[DOTW-2], prx4_ff}) + signed'({pry4_ff[DOTW-2], pry4_ff});
      den5_ff   <= DENW'(msum4_ff * esq_c);

      // stage 6: |dot| * |e|
      w6_ff.touch   <= touch5_ff;
      w6_ff.apply   <= apply5_ff;
      w6_ff.dot_neg <= dot5_ff[DOTW-1];
      w6_ff.ex_neg  <= dxn5_ff;
      w6_ff.ey_neg  <= dyn5_ff;
      w6_ff.px      <= adot_c * aex5_ff;
      w6_ff.py      <= adot_c * aey5_ff;
      w6_ff.den     <= den5_ff;
      w6_ff.ma      <= ma_ff[4];
      w6_ff.mb      <= mb_ff[4];
      w6_ff.avx     <= avx_ff[4];
      w6_ff.avy     <= avy_ff[4];
      w6_ff.bvx     <= bvx_ff[4];
      w6_ff.bvy     <= bvy_ff[4];
   end

   assign push = v_ff[5];
   assign word = w6_ff;

endmodule

`default_nettype wire

>>> rtl/dec_queue.sv
// ---------------------------------------------------------------------------
// dec_queue
// Small FIFO between front and back; drains one word per cycle when non-empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dec_queue
   import dec_pkg::*;
#(
   parameter int DEPTH = 16
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  dec_word_type      push_word,
   output logic              out_valid,
   output dec_word_type      out_word
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   dec_word_type  mem[DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          valid_ff;
   dec_word_type  word_ff;
   logic          pop;

   always_comb begin
      pop       = count_ff != '0;
      // pointers wrap at DEPTH, which need not be a power of two
      if (!push)
         wr_ptr_in = wr_ptr_ff;
      else if (wr_ptr_ff == AW'(DEPTH - 1))
         wr_ptr_in = '0;
      else
         wr_ptr_in = wr_ptr_ff + AW'(1);
      if (!pop)
         rd_ptr_in = rd_ptr_ff;
      else if (rd_ptr_ff == AW'(DEPTH - 1))
         rd_ptr_in = '0;
      else
         rd_ptr_in = rd_ptr_ff + AW'(1);
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         valid_ff  <= pop;
      end
      if (push) mem[wr_ptr_ff] <= push_word;
      if (pop) word_ff <= mem[rd_ptr_ff];
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && count_ff == CW'(DEPTH) && !pop))
      else $error("queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/dec_div.sv
// ---------------------------------------------------------------------------
// dec_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits in QW bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dec_div
   import dec_pkg::*;
(
   input  wire logic            clock,
   input  wire logic [NUMW-1:0] num,
   input  wire logic [DENW-1:0] den,
   output logic [QW-1:0]        quo
);

   logic [DENW-1:0] rem_ff[QW], rem_in[QW], rem_src[QW];
   logic [QW-1:0]   nq_ff[QW], nq_in[QW], nq_src[QW];
   logic [DENW-1:0] den_ff[QW], den_src[QW];
   logic [DENW:0]   t_c[QW], d_c[QW];
   logic            ge_c[QW];

   always_comb begin
      rem_src[0] = num[NUMW-1:QW];
      nq_src[0]  = num[QW-1:0];
      den_src[0] = den;
      for (int k = 1; k < QW; k++) begin
         rem_src[k] = rem_ff[k-1];
         nq_src[k]  = nq_ff[k-1];
         den_src[k] = den_ff[k-1];
      end
      for (int k = 0; k < QW; k++) begin
         t_c[k]    = {rem_src[k], nq_src[k][QW-1]};
         ge_c[k]   = t_c[k] >= {1'b0, den_src[k]};
         d_c[k]    = t_c[k] - {1'b0, den_src[k]};
         rem_in[k] = ge_c[k] ? d_c[k][DENW-1:0] : t_c[k][DENW-1:0];
         nq_in[k]  = {nq_src[k][QW-2:0], ge_c[k]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         rem_ff[k] <= rem_in[k];
         nq_ff[k]  <= nq_in[k];
         den_ff[k] <= den_src[k];
      end
   end

   assign quo = nq_ff[QW-1];

endmodule

`default_nettype wire

>>> rtl/dec_back.sv
// ---------------------------------------------------------------------------
// dec_back
// Scales by twice the other mass, divides by (ma+mb)|e|^2 and applies the
// saturated velocity corrections.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dec_back
   import dec_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  dec_word_type              in_word,
   output logic                      rsp_valid,
   output logic                      rsp_touching,
   output logic signed [VW-1:0]      rsp_a_new_vel_x,
   output logic signed [VW-1:0]      rsp_a_new_vel_y,
   output logic signed [VW-1:0]      rsp_b_new_vel_x,
   output logic signed [VW-1:0]      rsp_b_new_vel_y
);

   typedef struct packed {
      logic                 touch;
      logic                 apply;
      logic                 nax;
      logic                 nay;
      logic                 nbx;
      logic                 nby;
      logic signed [VW-1:0] avx;
      logic signed [VW-1:0] avy;
      logic signed [VW-1:0] bvx;
      logic signed [VW-1:0] bvy;
   } side_type;

   logic [QW:0]     v_ff, v_in;
   side_type        side_ff[QW+1];
   side_type        side_c;
   logic [NUMW-1:0] nax_ff, nay_ff, nbx_ff, nby_ff;
   logic [DENW-1:0] den_ff;
   logic [TMW-1:0]  tma_c, tmb_c;
   logic [QW-1:0]   qax, qay, qbx, qby;
   side_type        fin;

   logic                 valid_ff;
   logic                 touch_ff;
   logic signed [VW-1:0] ax_ff, ay_ff, bx_ff, by_ff;

   always_comb begin
      v_in  = {v_ff[QW-1:0], in_valid};
      tma_c = {in_word.ma, 1'b0};
      tmb_c = {in_word.mb, 1'b0};
      side_c.touch = in_word.touch;
      side_c.apply = in_word.apply;
      // disk B sees -dot
      side_c.nax   = in_word.dot_neg ^ in_word.ex_neg;
      side_c.nay   = in_word.dot_neg ^ in_word.ey_neg;
      side_c.nbx   = !in_word.dot_neg ^ in_word.ex_neg;
      side_c.nby   = !in_word.dot_neg ^ in_word.ey_neg;
      side_c.avx   = in_word.avx;
      side_c.avy   = in_word.avy;
      side_c.bvx   = in_word.bvx;
      side_c.bvy   = in_word.bvy;
      fin = side_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         v_ff     <= v_in;
         valid_ff <= v_ff[QW];
      end
      nax_ff <= {{(NUMW-PRW){1'b0}}, in_word.px} * tmb_c;
      nay_ff <= {{(NUMW-PRW){1'b0}}, in_word.py} * tmb_c;
      nbx_ff <= {{(NUMW-PRW){1'b0}}, in_word.px} * tma_c;
      nby_ff <= {{(NUMW-PRW){1'b0}}, in_word.py} * tma_c;
      den_ff <= in_word.den;
      side_ff[0] <= side_c;
      for (int s = 1; s <= QW; s++) side_ff[s] <= side_ff[s-1];

      touch_ff <= fin.touch;
      if (fin.apply) begin
         ax_ff <= sat_add(fin.avx, qax, fin.nax);
         ay_ff <= sat_add(fin.avy, qay, fin.nay);
         bx_ff <= sat_add(fin.bvx, qbx, fin.nbx);
         by_ff <= sat_add(fin.bvy, qby, fin.nby);
      end else begin
         ax_ff <= fin.avx;
         ay_ff <= fin.avy;
         bx_ff <= fin.bvx;
         by_ff <= fin.bvy;
      end
   end

   dec_div u_div_ax (.clock(clock), .num(nax_ff), .den(den_ff), .quo(qax));
   dec_div u_div_ay (.clock(clock), .num(nay_ff), .den(den_ff), .quo(qay));
   dec_div u_div_bx (.clock(clock), .num(nbx_ff), .den(den_ff), .quo(qbx));
   dec_div u_div_by (.clock(clock), .num(nby_ff), .den(den_ff), .quo(qby));

   assign rsp_valid       = valid_ff;
   assign rsp_touching    = touch_ff;
   assign rsp_a_new_vel_x = ax_ff;
   assign rsp_a_new_vel_y = ay_ff;
   assign rsp_b_new_vel_x = bx_ff;
   assign rsp_b_new_vel_y = by_ff;

endmodule

`default_nettype wire

>>> rtl/disk_elastic_collision.sv
// ---------------------------------------------------------------------------
// disk_elastic_collision
// Contact test and elastic velocity exchange for one pair of disks.
// ---------------------------------------------------------------------------
//   channel   handshake        fields
//   req_*     start / busy     two disks: pos, vel (Q16.16), mass, radius
//   rsp_*     rsp_valid strobe touching, four new velocities (Q16.16)
//
// One pair accepted per cycle while busy is low. A pair passes through 6 front
// stages, 2 queue registers, a scale stage, 34 divider stages and an output
// register; the 34-stage restoring divider sets the latency. Synchronous reset
// clears all valid state; no clearing pass. A credit comes back when its word
// leaves the queue, so with 16 credits busy stays low; results cannot be stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disk_elastic_collision
   import dec_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic signed [VW-1:0] req_a_pos_x,
   input  wire logic signed [VW-1:0] req_a_pos_y,
   input  wire logic signed [VW-1:0] req_a_vel_x,
   input  wire logic signed [VW-1:0] req_a_vel_y,
   input  wire logic [MW-1:0]        req_a_mass,
   input  wire logic [RW-1:0]        req_a_radius,
   input  wire logic signed [VW-1:0] req_b_pos_x,
   input  wire logic signed [VW-1:0] req_b_pos_y,
   input  wire logic signed [VW-1:0] req_b_vel_x,
   input  wire logic signed [VW-1:0] req_b_vel_y,
   input  wire logic [MW-1:0]        req_b_mass,
   input  wire logic [RW-1:0]        req_b_radius,
   output logic                      rsp_valid,
   output logic                      rsp_touching,
   output logic signed [VW-1:0]      rsp_a_new_vel_x,
   output logic signed [VW-1:0]      rsp_a_new_vel_y,
   output logic signed [VW-1:0]      rsp_b_new_vel_x,
   output logic signed [VW-1:0]      rsp_b_new_vel_y
);

   localparam int CRW = $clog2(QUEUE_DEPTH + 1);

   logic           accept;
   logic           push;
   dec_word_type   push_word;
   logic           q_valid;
   dec_word_type   q_word;
   logic [CRW-1:0] credits_ff, credits_in;

   // a credit is a free queue slot not claimed by a word in flight
   always_comb begin
      accept     = start && !busy;
      credits_in = credits_ff - CRW'(accept) + CRW'(q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff <= CRW'(QUEUE_DEPTH);
      end else begin
         credits_ff <= credits_in;
      end
   end

   assign busy = credits_ff == '0;

   dec_front u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .a_pos_x(req_a_pos_x), .a_pos_y(req_a_pos_y),
      .a_vel_x(req_a_vel_x), .a_vel_y(req_a_vel_y),
      .a_mass(req_a_mass), .a_radius(req_a_radius),
      .b_pos_x(req_b_pos_x), .b_pos_y(req_b_pos_y),
      .b_vel_x(req_b_vel_x), .b_vel_y(req_b_vel_y),
      .b_mass(req_b_mass), .b_radius(req_b_radius),
      .push(push), .word(push_word)
   );

   dec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_word(push_word),
      .out_valid(q_valid), .out_word(q_word)
   );

   dec_back u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_word(q_word),
      .rsp_valid(rsp_valid), .rsp_touching(rsp_touching),
      .rsp_a_new_vel_x(rsp_a_new_vel_x), .rsp_a_new_vel_y(rsp_a_new_vel_y),
      .rsp_b_new_vel_x(rsp_b_new_vel_x), .rsp_b_new_vel_y(rsp_b_new_vel_y)
   );

   a_credit_range: assert property (@(posedge clock) disable iff (reset)
      credits_ff <= CRW'(QUEUE_DEPTH))
      else $error("credit count above queue depth");

endmodule

`default_nettype wire
